// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the circle generator RTL.
// No dependencies; taken in by the top level with an include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, sampled on the rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/core/mcpg_pkg.sv =====
// Package for the midpoint circle point generator: config register indexes,
// octant order tables, decision constants and the step queue status type. No dependencies.
`timescale 1ns / 1ps

package mcpg_pkg;

  typedef enum logic [1:0] {
    CFG_RADIUS   = 2'd0,
    CFG_CENTER_X = 2'd1,
    CFG_CENTER_Y = 2'd2
  } cfg_idx_t;

  localparam int NUM_OCTANTS = 8;
  typedef logic [$clog2(NUM_OCTANTS)-1:0] octant_t;
  localparam octant_t LAST_OCTANT = octant_t'(NUM_OCTANTS - 1);

  // per octant, bit k: swap x/y, negate first coordinate, negate second
  // order: (+x,+y) (+y,+x) (-x,+y) (+y,-x) (-x,-y) (-y,-x) (+x,-y) (-y,+x)
  localparam logic [NUM_OCTANTS-1:0] OCT_SWAP  = 8'b1010_1010;
  localparam logic [NUM_OCTANTS-1:0] OCT_NEG_X = 8'b1011_0100;
  localparam logic [NUM_OCTANTS-1:0] OCT_NEG_Y = 8'b0111_1000;

  // decision start is 1 - r (3/2 taken as integer), updates add 2x+3 or 2(x-y)+5
  localparam int DEC_INIT   = 3 / 2;
  localparam int DEC_ADD_LT = 3;
  localparam int DEC_ADD_GE = 5;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/core/mcpg_front.sv =====
// Front end: takes ticks, runs the midpoint step and pushes one step word
// (offsets, centre, final flag) per drawing step. Depends on mcpg_pkg.
`timescale 1ns / 1ps

module mcpg_front #(
  parameter int RW    = 10,
  parameter int CW    = 12,
  parameter int REC_W = 2 * RW + 2 * CW + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick,
  input  logic             restart,
  input  logic [RW-1:0]    radius,
  input  logic [CW-1:0]    center_x,
  input  logic [CW-1:0]    center_y,
  output logic             q_push,
  output logic [REC_W-1:0] q_wdata
);

  localparam int XW = RW + 2;
  localparam int DW = RW + 4;

  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [DW-1:0] d_r, d_nxt;
  logic                 active_r, active_nxt;

  logic signed [XW-1:0] x0, y0, nx, ny;
  logic signed [DW-1:0] d0, d_upd;
  logic                 act0, emit, fin;

  always_comb begin
    if (restart) begin
      x0   = '0;
      y0   = XW'(radius);
      d0   = DW'(mcpg_pkg::DEC_INIT) - DW'(radius);
      act0 = 1'b1;
    end else begin
      x0   = x_r;
      y0   = y_r;
      d0   = d_r;
      act0 = active_r;
    end
    emit = act0 && !(x0 > y0);
    nx   = x0 + XW'(1);
    if (d0 < 0) begin
      d_upd = d0 + (DW'(x0) <<< 1) + DW'(mcpg_pkg::DEC_ADD_LT);
      ny    = y0;
    end else begin
      d_upd = d0 + (DW'(x0 - y0) <<< 1) + DW'(mcpg_pkg::DEC_ADD_GE);
      ny    = y0 - XW'(1);
    end
    fin = nx > ny;
  end

  always_comb begin
    x_nxt      = x_r;
    y_nxt      = y_r;
    d_nxt      = d_r;
    active_nxt = active_r;
    if (tick) begin
      x_nxt      = emit ? nx : x0;
      y_nxt      = emit ? ny : y0;
      d_nxt      = emit ? d_upd : d0;
      active_nxt = emit && !fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      y_r      <= '0;
      d_r      <= '0;
      active_r <= 1'b0;
    end else begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      d_r      <= d_nxt;
      active_r <= active_nxt;
    end
  end

  assign q_push  = tick && emit;
  assign q_wdata = {fin, center_y, center_x, y0[RW-1:0], x0[RW-1:0]};

endmodule

// ===== rtl/core/mcpg_queue.sv =====
// Short queue of step words between front and back end.
// Depends on mcpg_pkg for depth and status type.
`timescale 1ns / 1ps

module mcpg_queue #(
  parameter int REC_W = 45
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [REC_W-1:0]    wdata,
  input  logic                pop,
  output logic [REC_W-1:0]    rdata,
  output mcpg_pkg::q_status_t status
);

  logic [REC_W-1:0]          entry_r [mcpg_pkg::Q_DEPTH];
  logic [mcpg_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [mcpg_pkg::Q_AW:0]   count_r, count_nxt;
  logic                      do_push, do_pop;

  assign status.full  = count_r == (mcpg_pkg::Q_AW + 1)'(mcpg_pkg::Q_DEPTH);
  assign status.empty = count_r == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (mcpg_pkg::Q_AW + 1)'(do_push)
               - (mcpg_pkg::Q_AW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = entry_r[rd_ptr_r];

endmodule

// ===== rtl/core/mcpg_back.sv =====
// Back end: expands the step word at the queue head into eight octant points,
// one per cycle while the receiver pops, into the output register. Depends on mcpg_pkg.
`timescale 1ns / 1ps

module mcpg_back #(
  parameter int RW    = 10,
  parameter int CW    = 12,
  parameter int REC_W = 2 * RW + 2 * CW + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [REC_W-1:0]    q_rdata,
  input  mcpg_pkg::q_status_t q_status,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output logic [CW:0]         out_point_x,
  output logic [CW:0]         out_point_y,
  output logic                out_last_of_step,
  output logic                out_final_step
);

  localparam int SW = ((RW > CW) ? RW : CW) + 2;

  logic [RW-1:0]        hx, hy;
  logic signed [CW-1:0] hcx, hcy;
  logic                 hfin;

  mcpg_pkg::octant_t oct_r, oct_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CW:0]       px_r, py_r;
  logic              last_r, fin_r;

  logic                 load, taken, swap, neg_a, neg_b;
  logic signed [SW-1:0] a, b, px, py;

  assign {hfin, hcy, hcx, hy, hx} = q_rdata;

  assign taken = out_pop && out_valid_r;
  assign load  = !q_status.empty && (!out_valid_r || taken);
  assign q_pop = load && (oct_r == mcpg_pkg::LAST_OCTANT);

  always_comb begin
    swap  = mcpg_pkg::OCT_SWAP[oct_r];
    neg_a = mcpg_pkg::OCT_NEG_X[oct_r];
    neg_b = mcpg_pkg::OCT_NEG_Y[oct_r];
    a     = swap ? SW'(hy) : SW'(hx);
    b     = swap ? SW'(hx) : SW'(hy);
    px    = SW'(hcx) + (neg_a ? -a : a);
    py    = SW'(hcy) + (neg_b ? -b : b);
  end

  always_comb begin
    oct_nxt       = load ? oct_r + 1'b1 : oct_r;
    out_valid_nxt = load ? 1'b1 : (taken ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      oct_r       <= oct_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_r   <= px[CW:0];
      py_r   <= py[CW:0];
      last_r <= oct_r == mcpg_pkg::LAST_OCTANT;
      fin_r  <= hfin;
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_point_x      = px_r;
  assign out_point_y      = py_r;
  assign out_last_of_step = last_r;
  assign out_final_step   = fin_r;

endmodule

// ===== rtl/core/midpoint_circle_point_generator.sv =====
// Midpoint circle point generator, top level.
// Config: write radius, center_x, center_y on the cfg channel (cfg_ready is
// always high, unknown indexes are dropped); write only while the block is idle.
// Input: a word (in_restart) is taken when in_push is high and in_full is low.
// restart=1 begins a new circle, restart=0 advances the current one; a word
// after the circle is done yields nothing.
// Each drawing step yields eight point words, in octant order, on the out
// channel: the oldest is shown while out_empty is low and leaves on out_pop.
// The eighth carries last_of_step; all eight carry final_step on the last step.
// The first point of a step is shown after the step queue and the output register.
// Throughput: one point per cycle while steps are queued and the receiver pops, set
// by the single point path of the back end. A two-word step queue lets the front
// take words while the back still works on earlier steps.
// A stalled receiver holds the output word; the queue then fills and in_full
// rises until points drain.
// Reset (rst_n low, synchronous) clears the config, the circle state and the
// queue and marks the output register empty; the point data is not reset.
// Depends on mcpg_pkg, mcpg_front, mcpg_queue, mcpg_back and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module midpoint_circle_point_generator #(
  parameter int RADIUS_WIDTH = 10,
  parameter int COORD_WIDTH  = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  logic                   in_restart,
  output logic                   in_full,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [COORD_WIDTH:0]   out_point_x,
  output logic [COORD_WIDTH:0]   out_point_y,
  output logic                   out_last_of_step,
  output logic                   out_final_step,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [((RADIUS_WIDTH > COORD_WIDTH) ? RADIUS_WIDTH : COORD_WIDTH)-1:0] cfg_data
);

  localparam int REC_W = 2 * RADIUS_WIDTH + 2 * COORD_WIDTH + 1;

  logic [RADIUS_WIDTH-1:0] radius_r, radius_nxt;
  logic [COORD_WIDTH-1:0]  center_x_r, center_x_nxt, center_y_r, center_y_nxt;
  logic                    cfg_wr, tick, q_push, q_pop;
  logic [REC_W-1:0]        q_wdata, q_rdata;
  mcpg_pkg::q_status_t     q_status;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    radius_nxt   = radius_r;
    center_x_nxt = center_x_r;
    center_y_nxt = center_y_r;
    if (cfg_wr) begin
      case (mcpg_pkg::cfg_idx_t'(cfg_index))
        mcpg_pkg::CFG_RADIUS:   radius_nxt   = cfg_data[RADIUS_WIDTH-1:0];
        mcpg_pkg::CFG_CENTER_X: center_x_nxt = cfg_data[COORD_WIDTH-1:0];
        mcpg_pkg::CFG_CENTER_Y: center_y_nxt = cfg_data[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= '0;
      center_x_r <= '0;
      center_y_r <= '0;
    end else begin
      radius_r   <= radius_nxt;
      center_x_r <= center_x_nxt;
      center_y_r <= center_y_nxt;
    end
  end

  assign in_full = q_status.full;
  assign tick    = in_push && !in_full;

  mcpg_front #(
    .RW    (RADIUS_WIDTH),
    .CW    (COORD_WIDTH),
    .REC_W (REC_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (tick),
    .restart  (in_restart),
    .radius   (radius_r),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  mcpg_queue #(
    .REC_W (REC_W)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  mcpg_back #(
    .RW    (RADIUS_WIDTH),
    .CW    (COORD_WIDTH),
    .REC_W (REC_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_rdata          (q_rdata),
    .q_status         (q_status),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_last_of_step (out_last_of_step),
    .out_final_step   (out_final_step)
  );

  `ASSERT_NEVER(a_queue_overflow, clk, rst_n, q_push && q_status.full, "step pushed into full queue")
  `ASSERT_CLK(a_restart_emits, clk, rst_n, (tick && in_restart) |-> q_push, "restart gave no step")
  `ASSERT_CLK(a_step_contiguous, clk, rst_n, (out_pop && !out_empty && !out_last_of_step)
              |=> (!out_empty && (out_final_step == $past(out_final_step))), "step broken mid-way")

endmodule

// ===== tb/midpoint_circle_point_generator_tb.sv =====
`timescale 1ns / 1ps
// Testbench for midpoint_circle_point_generator: feeds restart/advance words,
// predicts the eight octant points of every step and checks each popped word.
// Depends on mcpg_pkg and the generator RTL.

module midpoint_circle_point_generator_tb;

  localparam int RW = 10;
  localparam int CW = 12;
  localparam int DW = (RW > CW) ? RW : CW;
  localparam logic [1:0] CFG_NONE = 2'd3;  // no register here, write is dropped
  localparam int DRAIN_CYCLES = 16;
  localparam int ITEM_TARGET = 250;
  localparam int MAX_ADVANCES = 40;

  typedef struct packed {
    logic [CW:0] x;
    logic [CW:0] y;
    logic        last;
    logic        fin;
  } point_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_push = 1'b0;
  logic          in_restart = 1'b0;
  logic          in_full;
  logic          out_empty;
  logic          out_pop = 1'b0;
  logic [CW:0]   out_point_x;
  logic [CW:0]   out_point_y;
  logic          out_last_of_step;
  logic          out_final_step;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = mcpg_pkg::CFG_RADIUS;
  logic [DW-1:0] cfg_data = '0;

  // predictor copy of the registers and circle state
  logic [RW-1:0]        radius_q;
  logic signed [CW-1:0] centre_x_q;
  logic signed [CW-1:0] centre_y_q;
  int                   step_x;
  int                   step_y;
  int                   decision_q;
  bit                   circle_on;

  point_t expected_points[$];
  logic   pending_words[$];
  int     send_idle_pct = 0;
  int     pop_stall_pct = 0;
  int     fault_count = 0;
  int     sent_words = 0;

  midpoint_circle_point_generator #(
    .RADIUS_WIDTH(RW),
    .COORD_WIDTH (CW)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_restart      (in_restart),
    .in_full         (in_full),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_last_of_step(out_last_of_step),
    .out_final_step  (out_final_step),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // one accepted word: maybe restart, then draw one step if the circle is open
  task automatic rasterize_step(input logic restart);
    int     cx, cy, x, y, ny;
    int     px[8];
    int     py[8];
    bit     fin;
    point_t p;
    if (restart) begin
      step_x = 0;
      step_y = radius_q;
      decision_q = 1 - int'(radius_q);
      circle_on = 1'b1;
    end
    if (!circle_on) return;
    x = step_x;
    y = step_y;
    if (x > y) begin
      circle_on = 1'b0;
      return;
    end
    cx = centre_x_q;
    cy = centre_y_q;
    px[0] = cx + x; py[0] = cy + y;
    px[1] = cx + y; py[1] = cy + x;
    px[2] = cx - x; py[2] = cy + y;
    px[3] = cx + y; py[3] = cy - x;
    px[4] = cx - x; py[4] = cy - y;
    px[5] = cx - y; py[5] = cy - x;
    px[6] = cx + x; py[6] = cy - y;
    px[7] = cx - y; py[7] = cy + x;
    ny = y;
    if (decision_q < 0) begin
      decision_q += 2 * x + 3;
    end else begin
      decision_q += 2 * (x - y) + 5;
      ny = y - 1;
    end
    fin = (x + 1) > ny;
    step_x = x + 1;
    step_y = ny;
    if (fin) circle_on = 1'b0;
    for (int k = 0; k < mcpg_pkg::NUM_OCTANTS; k++) begin
      p.x = px[k][CW:0];
      p.y = py[k][CW:0];
      p.last = (k == mcpg_pkg::NUM_OCTANTS - 1);
      p.fin = fin;
      expected_points.push_back(p);
    end
  endtask

  // driver: register model updates, input word acceptance and the next push
  always @(posedge clk) begin
    bit hold;
    if (!rst_n) begin
      radius_q = '0;
      centre_x_q = '0;
      centre_y_q = '0;
      step_x = 0;
      step_y = 0;
      decision_q = 0;
      circle_on = 1'b0;
      in_push <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mcpg_pkg::CFG_RADIUS:   radius_q = cfg_data[RW-1:0];
          mcpg_pkg::CFG_CENTER_X: centre_x_q = cfg_data[CW-1:0];
          mcpg_pkg::CFG_CENTER_Y: centre_y_q = cfg_data[CW-1:0];
          default: ;
        endcase
      end
      hold = in_push && in_full;
      if (in_push && !in_full) rasterize_step(pending_words.pop_front());
      if (hold || (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)) begin
        in_push <= 1'b1;
        in_restart <= pending_words[0];
      end else begin
        in_push <= 1'b0;
        in_restart <= 1'($urandom_range(1));
      end
    end
  end

  // monitor: check each popped point word against the oldest prediction
  always @(posedge clk) begin
    point_t got, want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        got.x = out_point_x;
        got.y = out_point_y;
        got.last = out_last_of_step;
        got.fin = out_final_step;
        if (expected_points.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected point word: x=%0d y=%0d last=%0b final=%0b",
                     $signed(got.x), $signed(got.y), got.last, got.fin);
        end else begin
          want = expected_points.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.last !== want.last ||
              got.fin !== want.fin) begin
            fault_count++;
            if (fault_count <= 10)
              $display("point mismatch: expected x=%0d y=%0d last=%0b final=%0b,",
                       $signed(want.x), $signed(want.y), want.last, want.fin,
                       " got x=%0d y=%0d last=%0b final=%0b",
                       $signed(got.x), $signed(got.y), got.last, got.fin);
          end
        end
      end
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [DW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_word(input logic restart, input int count);
    repeat (count) pending_words.push_back(restart);
    sent_words += count;
  endtask

  // wait for every word to go in and every point to come out, then settle
  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_push || expected_points.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] pick_coord();
    case ($urandom_range(7))
      0:       return DW'(12'h7ff);
      1:       return DW'(12'h800);
      default: return DW'($urandom);
    endcase
  endfunction

  initial begin
    int            cur_radius;
    int            steps;
    int            adv;
    logic [DW-1:0] word;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // advance with no circle open draws nothing
    queue_word(1'b0, 1);
    drain();

    // zero radius: centre eight times, final step, then nothing more
    write_reg(mcpg_pkg::CFG_RADIUS, '0);
    write_reg(mcpg_pkg::CFG_CENTER_X, '0);
    write_reg(mcpg_pkg::CFG_CENTER_Y, '0);
    write_reg(CFG_NONE, '1);
    queue_word(1'b1, 1);
    queue_word(1'b0, 1);
    drain();

    // widest circle at the corner of the coordinate range, restarted mid-way
    write_reg(mcpg_pkg::CFG_RADIUS, '1);
    write_reg(mcpg_pkg::CFG_CENTER_X, DW'(12'h7ff));
    write_reg(mcpg_pkg::CFG_CENTER_Y, DW'(12'h800));
    queue_word(1'b1, 1);
    queue_word(1'b0, 3);
    queue_word(1'b1, 1);
    queue_word(1'b0, 2);
    drain();

    // circle still open: centre moves at once, radius waits for the restart
    write_reg(mcpg_pkg::CFG_CENTER_X, DW'(12'h800));
    write_reg(mcpg_pkg::CFG_CENTER_Y, DW'(12'h7ff));
    write_reg(mcpg_pkg::CFG_RADIUS, DW'(5));
    queue_word(1'b0, 3);
    queue_word(1'b1, 1);
    queue_word(1'b0, 5);
    drain();
    cur_radius = 5;

    for (int phase = 0; sent_words < ITEM_TARGET; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 54; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 54; end
        default: begin send_idle_pct = 33; pop_stall_pct = 33; end
      endcase
      if ($urandom_range(3) != 0) begin
        // mostly small circles, now and then a big one cut short
        cur_radius = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(24);
        word = DW'($urandom);
        word[RW-1:0] = cur_radius[RW-1:0];
        write_reg(mcpg_pkg::CFG_RADIUS, word);
      end
      if ($urandom_range(3) != 0) write_reg(mcpg_pkg::CFG_CENTER_X, pick_coord());
      if ($urandom_range(3) != 0) write_reg(mcpg_pkg::CFG_CENTER_Y, pick_coord());
      if ($urandom_range(3) == 0) write_reg(CFG_NONE, DW'($urandom));

      // carry on the previous circle, or stray advances after it finished
      if ($urandom_range(1) != 0) queue_word(1'b0, $urandom_range(1, 4));
      repeat (4) begin
        steps = cur_radius * 707 / 1000 + 2;
        if ($urandom_range(9) < 7)
          adv = steps - 1 + $urandom_range(2);
        else
          adv = $urandom_range(steps - 1);
        if (adv > MAX_ADVANCES) adv = MAX_ADVANCES;
        queue_word(1'b1, 1);
        queue_word(1'b0, adv);
      end
      drain();
    end

    send_idle_pct = 0;
    pop_stall_pct = 0;
    drain();
    if (fault_count == 0 && expected_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mcpg_pkg.sv
rtl/core/mcpg_front.sv
rtl/core/mcpg_queue.sv
rtl/core/mcpg_back.sv
rtl/core/midpoint_circle_point_generator.sv
tb/midpoint_circle_point_generator_tb.sv
